### rtl/rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned DistFracBits = 16;
  localparam int unsigned EpsBits = 52;
  localparam int unsigned DistBits = 32;

  // Derived arithmetic widths.
  localparam int unsigned EdgeBits = CoordBits + 1;
  localparam int unsigned NrmBits = 2 * EdgeBits + 2;
  localparam int unsigned DotBits = NrmBits + EdgeBits + 2;
  localparam int unsigned NumBits = DotBits + DistFracBits;
  localparam int unsigned QuoBits = DistBits + 1;

  // Outcome codes.
  localparam logic [1:0] OutHit      = 2'd0;
  localparam logic [1:0] OutParallel = 2'd1;
  localparam logic [1:0] OutBehind   = 2'd2;
  localparam logic [1:0] OutOutside  = 2'd3;

  typedef struct packed {
    logic [3*CoordBits-1:0] vertex_c;
    logic [3*CoordBits-1:0] vertex_b;
    logic [3*CoordBits-1:0] vertex_a;
    logic signed [CoordBits-1:0] direction_z;
    logic signed [CoordBits-1:0] direction_y;
    logic signed [CoordBits-1:0] direction_x;
    logic signed [CoordBits-1:0] origin_z;
    logic signed [CoordBits-1:0] origin_y;
    logic signed [CoordBits-1:0] origin_x;
  } rti_in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic [1:0]          outcome;
    logic                hit;
  } rti_out_t;

endpackage
`default_nettype wire

### rtl/ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall   rti_pkg::rti_in_t
// out       output     out_valid/out_stall rti_pkg::rti_out_t
// cfg       input      cfg_valid/cfg_ready parallel_epsilon (52 bits)
//
// One item enters per cycle while the output is not stalled. The pipeline has four arithmetic stages,
// a classification stage, a restoring divider with one quotient bit per stage,
// and the output register.
// Reset clears every valid bit and sets parallel_epsilon to 1.
// A stall on the output while out_valid is high halts the whole pipeline; in_stall is then high.
module ray_triangle_intersect_unit (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire rti_pkg::rti_in_t   in_data_i,
  output logic                    out_valid,
  input  wire                     out_stall,
  output rti_pkg::rti_out_t       out_data_o,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [rti_pkg::EpsBits-1:0] cfg_data_i
);
  import rti_pkg::*;

  localparam int unsigned Nst = 5 + QuoBits;
  localparam int unsigned C = CoordBits;

  typedef logic signed [C:0] e_t;
  typedef logic signed [NrmBits-1:0] n_t;
  typedef logic signed [DotBits-1:0] d_t;

  logic              adv;
  logic [EpsBits-1:0] eps_q;
  logic [Nst-1:0]    vld_q;

  assign adv       = !out_stall || !out_valid;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsBits'(1);
    end else if (cfg_valid) begin
      eps_q <= cfg_data_i;
    end
  end

  // Valid bits move with the data when the pipe advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Nst-2:0], in_valid};
      out_valid <= vld_q[Nst-1];
    end
  end

  // Stage 1: unpack and form difference vectors.
  e_t e1_q [3], e2_q [3], dr_q [3];
  e_t po_q [3][3]; // vertex minus origin for a, b, c
  logic signed [C-1:0] vs [3][3];
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        case (v)
          0: vs[v][k] = in_data_i.vertex_a[k*C +: C];
          1: vs[v][k] = in_data_i.vertex_b[k*C +: C];
          default: vs[v][k] = in_data_i.vertex_c[k*C +: C];
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= e_t'(vs[1][k]) - e_t'(vs[0][k]);
        e2_q[k] <= e_t'(vs[2][k]) - e_t'(vs[0][k]);
      end
      dr_q[0] <= e_t'(in_data_i.direction_x);
      dr_q[1] <= e_t'(in_data_i.direction_y);
      dr_q[2] <= e_t'(in_data_i.direction_z);
      for (int v = 0; v < 3; v++) begin
        po_q[v][0] <= e_t'(vs[v][0]) - e_t'(in_data_i.origin_x);
        po_q[v][1] <= e_t'(vs[v][1]) - e_t'(in_data_i.origin_y);
        po_q[v][2] <= e_t'(vs[v][2]) - e_t'(in_data_i.origin_z);
      end
    end
  end

  // Stage 2: products for the normal and for each edge's cross product.
  n_t pn_q [3][2];
  n_t pc_q [3][3][2];
  e_t dr2_q [3], ao2_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pn_q[k][0] <= n_t'(e1_q[(k+1)%3]) * n_t'(e2_q[(k+2)%3]);
        pn_q[k][1] <= n_t'(e1_q[(k+2)%3]) * n_t'(e2_q[(k+1)%3]);
        dr2_q[k] <= dr_q[k];
        ao2_q[k] <= po_q[0][k];
        for (int v = 0; v < 3; v++) begin
          pc_q[v][k][0] <= n_t'(po_q[v][(k+1)%3]) * n_t'(po_q[(v+1)%3][(k+2)%3]);
          pc_q[v][k][1] <= n_t'(po_q[v][(k+2)%3]) * n_t'(po_q[(v+1)%3][(k+1)%3]);
        end
      end
    end
  end

  // Stage 3: subtract to finish the cross products.
  n_t nrm_q [3];
  n_t cr_q [3][3];
  e_t dr3_q [3], ao3_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nrm_q[k] <= pn_q[k][0] - pn_q[k][1];
        dr3_q[k] <= dr2_q[k];
        ao3_q[k] <= ao2_q[k];
        for (int v = 0; v < 3; v++) cr_q[v][k] <= pc_q[v][k][0] - pc_q[v][k][1];
      end
    end
  end

  // Stage 4: dot product terms.
  d_t tdd_q [3], ttt_q [3];
  d_t tsd_q [3][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        tdd_q[k] <= d_t'(nrm_q[k]) * d_t'(dr3_q[k]);
        ttt_q[k] <= d_t'(nrm_q[k]) * d_t'(ao3_q[k]);
        for (int v = 0; v < 3; v++) tsd_q[v][k] <= d_t'(cr_q[v][k]) * d_t'(dr3_q[k]);
      end
    end
  end

  // Stage 5: sums, classification and divider setup.
  d_t dd, tt, sd [3];
  logic [DotBits-1:0] ad, at;
  logic par, beh, outs;
  always_comb begin
    dd = tdd_q[0] + tdd_q[1] + tdd_q[2];
    tt = ttt_q[0] + ttt_q[1] + ttt_q[2];
    outs = 1'b0;
    for (int v = 0; v < 3; v++) begin
      sd[v] = tsd_q[v][0] + tsd_q[v][1] + tsd_q[v][2];
      if (sd[v] != '0 && (sd[v][DotBits-1] != dd[DotBits-1])) outs = 1'b1;
    end
    ad = dd[DotBits-1] ? DotBits'(-dd) : DotBits'(dd);
    at = tt[DotBits-1] ? DotBits'(-tt) : DotBits'(tt);
    par = (dd == '0) || (ad < DotBits'(eps_q));
    beh = (tt != '0) && (tt[DotBits-1] != dd[DotBits-1]);
  end

  // Divider stages: numerator aligned so the quotient holds QuoBits bits.
  logic [1:0]          oc_q  [QuoBits+1];
  logic [DotBits-1:0]  den_q [QuoBits+1];
  logic [NumBits-1:0]  rem_q [QuoBits+1];
  logic [QuoBits-1:0]  quo_q [QuoBits+1];
  logic                sat_q [QuoBits+1];
  logic [NumBits-1:0]  num_w;
  assign num_w = {at, {DistFracBits{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q[0]  <= par ? OutParallel : (beh ? OutBehind : (outs ? OutOutside : OutHit));
      den_q[0] <= ad;
      rem_q[0] <= num_w;
      quo_q[0] <= '0;
      // Quotient bits above the tracked range force saturation.
      sat_q[0] <= ad != '0 && ((num_w >> QuoBits) >= NumBits'(ad));
    end
  end

  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    localparam int unsigned Sh = QuoBits - 1 - g;
    logic [NumBits+QuoBits-1:0] dsh;
    logic                       ge;
    assign dsh = {{QuoBits{1'b0}}, NumBits'(den_q[g])} << Sh;
    assign ge  = {{QuoBits{1'b0}}, rem_q[g]} >= dsh;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        oc_q[g+1]  <= oc_q[g];
        den_q[g+1] <= den_q[g];
        sat_q[g+1] <= sat_q[g];
        rem_q[g+1] <= ge ? NumBits'({{QuoBits{1'b0}}, rem_q[g]} - dsh) : rem_q[g];
        quo_q[g+1] <= {quo_q[g][QuoBits-2:0], ge};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.hit     <= (oc_q[QuoBits] == OutHit);
      out_data_o.outcome <= oc_q[QuoBits];
      if (oc_q[QuoBits] == OutParallel || oc_q[QuoBits] == OutBehind) begin
        out_data_o.distance <= '0;
      end else if (sat_q[QuoBits] || quo_q[QuoBits][QuoBits-1]) begin
        out_data_o.distance <= '1;
      end else begin
        out_data_o.distance <= quo_q[QuoBits][DistBits-1:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data_o.hit == (out_data_o.outcome == OutHit)))
    else $error("hit flag disagrees with outcome");
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data_o.outcome == OutParallel || out_data_o.outcome == OutBehind)
    |-> out_data_o.distance == '0)
    else $error("nonzero distance on rejected item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
